FILE: src/file_transfer_receiver_fsm_macros.svh
// Assertion helpers for the file-transfer receiver.
`ifndef FILE_TRANSFER_RECEIVER_FSM_MACROS_SVH
`define FILE_TRANSFER_RECEIVER_FSM_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FTR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FTR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ftr_pkg.sv
package ftr_pkg;

  typedef enum logic [1:0] {
    ST_IDLE         = 2'd0,
    ST_CONNECTED    = 2'd1,
    ST_TRANSFERRING = 2'd2
  } ftr_status_t;

  typedef enum logic [2:0] {
    RP_NONE   = 3'd0,
    RP_ACK    = 3'd1,
    RP_INIT   = 3'd2,
    RP_RETRY  = 3'd3,
    RP_TOOBIG = 3'd4,
    RP_FAILED = 3'd5,
    RP_PURGE  = 3'd6
  } ftr_reply_t;

  localparam logic [2:0] OP_CONNECT = 3'd0;
  localparam logic [2:0] OP_INIT    = 3'd1;
  localparam logic [2:0] OP_SIZE    = 3'd2;
  localparam logic [2:0] OP_DATA    = 3'd3;
  localparam logic [2:0] OP_EOF     = 3'd4;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FILE_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD   = 1'b1;

  localparam logic [31:0] MAX_FILE_SIZE_RST = 32'd209715200;  // 200 MiB
  localparam logic [15:0] MAX_PAYLOAD_RST   = 16'd1024;

  typedef struct packed {
    logic [2:0]  opcode;
    logic        checksum_ok;
    logic        payload_timeout;
    logic [15:0] payload_length;
    logic [15:0] frame_sequence;
    logic [31:0] announced_size;
  } ftr_in_t;

  typedef struct packed {
    ftr_reply_t  reply_code;
    logic        store_payload;
    logic [31:0] store_offset;
    logic        transfer_done;
    ftr_status_t link_status;
  } ftr_out_t;

  typedef struct packed {
    ftr_status_t status;
    logic [15:0] expected_seq;
    logic [31:0] file_size;
    logic [31:0] received_count;
  } ftr_state_t;

  typedef struct packed {
    logic [31:0] max_file_size;
    logic [15:0] max_payload;
  } ftr_cfg_t;

endpackage

FILE: src/ftr_decide.sv
module ftr_decide
  import ftr_pkg::*;
(
  input  ftr_in_t    item,
  input  ftr_state_t st,
  input  ftr_cfg_t   cfg,
  output ftr_out_t   res,
  output ftr_state_t st_next
);

  logic purge;

  // Screen the frame before looking at the command.
  assign purge = (item.payload_length > cfg.max_payload) ||
                 ((item.payload_length != 16'd0) && item.payload_timeout);

  always_comb begin
    st_next           = st;
    res.reply_code    = RP_NONE;
    res.store_payload = 1'b0;
    res.store_offset  = 32'd0;
    res.transfer_done = 1'b0;

    if (purge) begin
      res.reply_code = RP_PURGE;
    end else if (!item.checksum_ok) begin
      res.reply_code = RP_RETRY;
    end else begin
      case (item.opcode)
        OP_CONNECT: begin
          if (st.status == ST_IDLE || st.status == ST_CONNECTED) begin
            res.reply_code       = RP_ACK;
            st_next.expected_seq = 16'd0;
            st_next.status       = ST_CONNECTED;
          end else begin
            res.reply_code = RP_INIT;
            st_next.status = ST_IDLE;
          end
        end
        OP_INIT: begin
          res.reply_code = RP_ACK;
          st_next.status = ST_IDLE;
        end
        OP_SIZE: begin
          if (st.status == ST_CONNECTED) begin
            st_next.file_size = item.announced_size;
            if (item.announced_size > cfg.max_file_size) begin
              res.reply_code = RP_TOOBIG;
            end else begin
              res.reply_code         = RP_ACK;
              st_next.received_count = 32'd0;
              st_next.status         = ST_TRANSFERRING;
            end
          end else begin
            res.reply_code = RP_INIT;
          end
        end
        OP_DATA: begin
          if (st.status != ST_TRANSFERRING) begin
            res.reply_code = RP_INIT;
          end else if (item.frame_sequence == st.expected_seq) begin
            res.reply_code         = RP_ACK;
            res.store_payload      = 1'b1;
            res.store_offset       = st.received_count;
            st_next.expected_seq   = st.expected_seq + 16'd1;
            st_next.received_count = st.received_count + {16'd0, item.payload_length};
          end else if (item.frame_sequence < st.expected_seq) begin
            // duplicate word: ack and drop
            res.reply_code = RP_ACK;
          end else begin
            res.reply_code = RP_INIT;
          end
        end
        OP_EOF: begin
          if (st.status == ST_TRANSFERRING) begin
            if (st.received_count == st.file_size) begin
              res.reply_code    = RP_ACK;
              res.transfer_done = 1'b1;
              st_next.file_size = 32'd0;
            end else begin
              res.reply_code = RP_FAILED;
            end
            st_next.status = ST_IDLE;
          end else begin
            res.reply_code = RP_INIT;
          end
        end
        default: begin
          res.reply_code = RP_NONE;
          st_next.status = ST_IDLE;
        end
      endcase
    end

    res.link_status = st_next.status;
  end

endmodule

FILE: src/file_transfer_receiver_fsm.sv
// channel   | handshake                | payload
// ----------+--------------------------+-------------------------------
// input     | in_valid / in_stall      | in_item  (ftr_in_t), one header
// output    | out_valid / out_stall    | out_item (ftr_out_t), one reply
// config    | wr_en                    | wr_index, wr_data
//
// One frame header per cycle while out_stall is low; a header is taken into the
// input register, then decided into the reply register that drives out_item.
// The link state updates as a header moves into the reply register, so the
// next header sees it without a bubble.
// rst is synchronous: link idle, counters zero, limits back to defaults.
// With the reply held by out_stall, one more header is still taken into
// the input register; in_stall rises only when both registers are full.
`include "file_transfer_receiver_fsm_macros.svh"

module file_transfer_receiver_fsm
  import ftr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ftr_in_t              in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ftr_out_t             out_item,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [31:0]          wr_data
);

  logic       s1_valid;
  ftr_in_t    s1_item;
  ftr_state_t st;
  ftr_state_t st_next;
  ftr_cfg_t   cfg;
  ftr_out_t   res;
  logic       out_ready;

  assign out_ready = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !out_ready;

  ftr_decide u_decide (
    .item    (s1_item),
    .st      (st),
    .cfg     (cfg),
    .res     (res),
    .st_next (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid          <= 1'b0;
      out_valid         <= 1'b0;
      st.status         <= ST_IDLE;
      st.expected_seq   <= 16'd0;
      st.file_size      <= 32'd0;
      st.received_count <= 32'd0;
      cfg.max_file_size <= MAX_FILE_SIZE_RST;
      cfg.max_payload   <= MAX_PAYLOAD_RST;
    end else begin
      if (wr_en) begin
        case (wr_index)
          CFG_MAX_FILE_SIZE: cfg.max_file_size <= wr_data;
          CFG_MAX_PAYLOAD:   cfg.max_payload   <= wr_data[15:0];
          default: ;
        endcase
      end
      if (out_ready) begin
        out_valid <= s1_valid;
        if (s1_valid) begin
          st <= st_next;
        end
      end
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_item;
    end
    if (out_ready && s1_valid) begin
      out_item <= res;
    end
  end

  `FTR_ASSERT_NOW(a_store_is_ack, out_valid && out_item.store_payload, out_item.reply_code == RP_ACK && out_item.link_status == ST_TRANSFERRING, "stored word without ack while transferring")
  `FTR_ASSERT_NOW(a_done_is_idle, out_valid && out_item.transfer_done, out_item.reply_code == RP_ACK && out_item.link_status == ST_IDLE, "transfer done without ack to idle")
  `FTR_ASSERT_NOW(a_offset_zero, out_valid && !out_item.store_payload, out_item.store_offset == 32'd0, "offset set on a word not stored")
  `FTR_ASSERT_NEXT(a_stall_holds_stage, in_stall, s1_valid, "input register emptied while stalled")

endmodule
